FILE: src/ffca_pkg.sv
package ffca_pkg;

  // Geometry of the bitmap and the slot table.
  localparam int BLOCKS  = 1024;
  localparam int SLOTS   = 128;
  localparam int BLOCK_W = $clog2(BLOCKS);
  localparam int CNT_W   = $clog2(BLOCKS + 1);
  localparam int SLOT_W  = $clog2(SLOTS);

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NOSPACE  = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_NOTFOUND = 2'd3
  } status_t;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    ST_CLEAR   = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_SLOT    = 8'b0000_0100,
    ST_SCAN    = 8'b0000_1000,
    ST_MARK    = 8'b0001_0000,
    ST_FREE_RD = 8'b0010_0000,
    ST_FREE    = 8'b0100_0000,
    ST_DONE    = 8'b1000_0000
  } state_t;

endpackage

FILE: src/first_fit_contiguous_allocator.sv
// Channel    Handshake              Payload
// request    req_valid / req_stall  kind, size, handle
// result     rsp_valid / rsp_stall  status, slot, run_start, used_total
//
// After reset the bitmap memory is swept to zero, one block a cycle, while req_stall
// is high. An allocate walks the valid bits for an idle slot, scans the bitmap
// through its single read port, and marks the run; a free reads the slot table,
// then clears the run through the single write port of the bitmap. Either then
// loads the output register. One request is in work at a time; a finished result
// waits in the output register while rsp_stall is high.
module first_fit_contiguous_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic                         kind,
  input  logic [ffca_pkg::CNT_W-1:0]   size,
  input  logic [ffca_pkg::SLOT_W-1:0]  handle,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [1:0]                   status,
  output logic [ffca_pkg::SLOT_W-1:0]  slot,
  output logic [ffca_pkg::BLOCK_W-1:0] run_start,
  output logic [ffca_pkg::CNT_W-1:0]   used_total
);

  localparam int BW = ffca_pkg::BLOCK_W;
  localparam int CW = ffca_pkg::CNT_W;
  localparam int SW = ffca_pkg::SLOT_W;

  // Memories: block bitmap and slot start/length table.
  logic                  bm_mem [ffca_pkg::BLOCKS];
  logic [BW-1:0]         tbl_start_mem [ffca_pkg::SLOTS];
  logic [CW-1:0]         tbl_len_mem [ffca_pkg::SLOTS];

  logic                  bm_we;
  logic                  bm_wdata;
  logic                  bm_rdata;
  logic                  tbl_we;
  logic [BW-1:0]         tbl_rstart;
  logic [CW-1:0]         tbl_rlen;

  // Control and datapath registers.
  ffca_pkg::state_t      state, state_next;
  logic [BW-1:0]         bm_addr, bm_addr_next;
  logic [BW-1:0]         rd_blk;
  logic                  rd_vld, rd_vld_next;
  logic [CW-1:0]         run_len, run_len_next;
  logic [BW-1:0]         run_begin, run_begin_next;
  logic [CW-1:0]         req_size, req_size_next;
  logic [SW-1:0]         req_handle, req_handle_next;
  logic [SW-1:0]         slot_ptr, slot_ptr_next;
  logic [CW-1:0]         cnt, cnt_next;
  logic [CW-1:0]         used_count, used_count_next;
  logic [ffca_pkg::SLOTS-1:0] slot_valid, slot_valid_next;
  ffca_pkg::status_t     res_status, res_status_next;
  logic [SW-1:0]         res_slot, res_slot_next;
  logic [BW-1:0]         res_start, res_start_next;

  logic                  req_accept;
  logic                  out_load;
  logic                  handle_live;
  logic [CW-1:0]         run_inc;

  assign req_stall   = (state != ffca_pkg::ST_IDLE);
  assign req_accept  = req_valid && !req_stall;
  assign out_load    = (state == ffca_pkg::ST_DONE) && (!rsp_valid || !rsp_stall);
  assign handle_live = (32'(handle) < ffca_pkg::SLOTS) && slot_valid[handle];
  assign run_inc     = run_len + CW'(1);

  // Bitmap memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (bm_we) begin
      bm_mem[bm_addr] <= bm_wdata;
    end
    bm_rdata <= bm_mem[bm_addr];
  end

  // Slot table memory: written at the allocated slot, read at the request handle.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_start_mem[slot_ptr] <= res_start;
      tbl_len_mem[slot_ptr]   <= req_size;
    end
    tbl_rstart <= tbl_start_mem[handle];
    tbl_rlen   <= tbl_len_mem[handle];
  end

  // Sequencer.
  always_comb begin
    state_next      = state;
    bm_addr_next    = bm_addr;
    rd_vld_next     = 1'b0;
    run_len_next    = run_len;
    run_begin_next  = run_begin;
    req_size_next   = req_size;
    req_handle_next = req_handle;
    slot_ptr_next   = slot_ptr;
    cnt_next        = cnt;
    used_count_next = used_count;
    slot_valid_next = slot_valid;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_start_next  = res_start;
    bm_we           = 1'b0;
    bm_wdata        = 1'b0;
    tbl_we          = 1'b0;

    unique case (state)
      ffca_pkg::ST_CLEAR: begin
        bm_we        = 1'b1;
        bm_wdata     = 1'b0;
        bm_addr_next = bm_addr + BW'(1);
        if (bm_addr == BW'(ffca_pkg::BLOCKS - 1)) begin
          state_next = ffca_pkg::ST_IDLE;
        end
      end

      ffca_pkg::ST_IDLE: begin
        if (req_accept) begin
          if (kind == ffca_pkg::KIND_ALLOC) begin
            req_size_next = size;
            slot_ptr_next = '0;
            state_next    = ffca_pkg::ST_SLOT;
          end else begin
            req_handle_next = handle;
            if (handle_live) begin
              state_next = ffca_pkg::ST_FREE_RD;
            end else begin
              res_status_next = ffca_pkg::STATUS_NOTFOUND;
              res_slot_next   = handle;
              res_start_next  = '0;
              state_next      = ffca_pkg::ST_DONE;
            end
          end
        end
      end

      // Walk the valid bits for the lowest idle slot.
      ffca_pkg::ST_SLOT: begin
        if (!slot_valid[slot_ptr]) begin
          if (req_size == '0 || req_size > CW'(ffca_pkg::BLOCKS)) begin
            res_status_next = ffca_pkg::STATUS_NOSPACE;
            res_slot_next   = '0;
            res_start_next  = '0;
            state_next      = ffca_pkg::ST_DONE;
          end else begin
            bm_addr_next = '0;
            run_len_next = '0;
            state_next   = ffca_pkg::ST_SCAN;
          end
        end else if (slot_ptr == SW'(ffca_pkg::SLOTS - 1)) begin
          res_status_next = ffca_pkg::STATUS_FULL;
          res_slot_next   = '0;
          res_start_next  = '0;
          state_next      = ffca_pkg::ST_DONE;
        end else begin
          slot_ptr_next = slot_ptr + SW'(1);
        end
      end

      // Stream the bitmap and track the current run of free blocks.
      ffca_pkg::ST_SCAN: begin
        bm_addr_next = bm_addr + BW'(1);
        rd_vld_next  = 1'b1;
        if (rd_vld) begin
          if (!bm_rdata) begin
            run_len_next = run_inc;
            if (run_len == '0) begin
              run_begin_next = rd_blk;
            end
            if (run_inc == req_size) begin
              res_start_next = (run_len == '0) ? rd_blk : run_begin;
              bm_addr_next   = (run_len == '0) ? rd_blk : run_begin;
              cnt_next       = req_size;
              rd_vld_next    = 1'b0;
              state_next     = ffca_pkg::ST_MARK;
            end else if (rd_blk == BW'(ffca_pkg::BLOCKS - 1)) begin
              res_status_next = ffca_pkg::STATUS_NOSPACE;
              res_slot_next   = '0;
              res_start_next  = '0;
              rd_vld_next     = 1'b0;
              state_next      = ffca_pkg::ST_DONE;
            end
          end else begin
            run_len_next = '0;
            if (rd_blk == BW'(ffca_pkg::BLOCKS - 1)) begin
              res_status_next = ffca_pkg::STATUS_NOSPACE;
              res_slot_next   = '0;
              res_start_next  = '0;
              rd_vld_next     = 1'b0;
              state_next      = ffca_pkg::ST_DONE;
            end
          end
        end
      end

      // Set the run's blocks, then record the slot.
      ffca_pkg::ST_MARK: begin
        bm_we        = 1'b1;
        bm_wdata     = 1'b1;
        bm_addr_next = bm_addr + BW'(1);
        cnt_next     = cnt - CW'(1);
        if (cnt == CW'(1)) begin
          tbl_we                    = 1'b1;
          slot_valid_next[slot_ptr] = 1'b1;
          used_count_next           = used_count + req_size;
          res_status_next           = ffca_pkg::STATUS_OK;
          res_slot_next             = slot_ptr;
          state_next                = ffca_pkg::ST_DONE;
        end
      end

      // Table data for the handle is available this cycle.
      ffca_pkg::ST_FREE_RD: begin
        bm_addr_next   = tbl_rstart;
        res_start_next = tbl_rstart;
        cnt_next       = tbl_rlen;
        req_size_next  = tbl_rlen;
        state_next     = ffca_pkg::ST_FREE;
      end

      // Clear the slot's blocks; a live run is always fully marked.
      ffca_pkg::ST_FREE: begin
        bm_we        = 1'b1;
        bm_wdata     = 1'b0;
        bm_addr_next = bm_addr + BW'(1);
        cnt_next     = cnt - CW'(1);
        if (cnt <= CW'(1)) begin
          slot_valid_next[req_handle] = 1'b0;
          used_count_next             = used_count - req_size;
          res_status_next             = ffca_pkg::STATUS_OK;
          res_slot_next               = req_handle;
          state_next                  = ffca_pkg::ST_DONE;
        end
      end

      ffca_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = ffca_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = ffca_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ffca_pkg::ST_CLEAR;
      bm_addr    <= '0;
      rd_vld     <= 1'b0;
      slot_valid <= '0;
      used_count <= '0;
    end else begin
      state      <= state_next;
      bm_addr    <= bm_addr_next;
      rd_vld     <= rd_vld_next;
      slot_valid <= slot_valid_next;
      used_count <= used_count_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rd_blk     <= bm_addr;
    run_len    <= run_len_next;
    run_begin  <= run_begin_next;
    req_size   <= req_size_next;
    req_handle <= req_handle_next;
    slot_ptr   <= slot_ptr_next;
    cnt        <= cnt_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_start  <= res_start_next;
  end

  // Output register holds the result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status     <= res_status;
      slot       <= res_slot;
      run_start  <= res_start;
      used_total <= used_count;
    end
  end

endmodule
